// ----- hdl/ahba_pkg.sv -----
// Package with the shared types and constants of the additive hash bucket aggregator.
`default_nettype none
package ahba_pkg;

  localparam int unsigned BUCKETS     = 16;
  localparam int unsigned BIDX_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned RESIDUE_MOD = 101;
  localparam int unsigned RES_W       = 7;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SEL_W       = 7;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 56;

  typedef enum logic {
    OP_KEY_BYTE = 1'b0,
    OP_QUERY    = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ACK    = 1'b0,
    KIND_ANSWER = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
  } bucket_entry_t;

  localparam int unsigned ENTRY_W = $bits(bucket_entry_t);

  // Adds one byte to a residue below the modulus; the sum stays below four moduli.
  function automatic logic [RES_W-1:0] residue_add(input logic [RES_W-1:0] res,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    logic [BYTE_W:0] r;
    s = {2'b00, res} + {1'b0, b};
    if (s >= (BYTE_W+1)'(3 * RESIDUE_MOD)) begin
      r = s - (BYTE_W+1)'(3 * RESIDUE_MOD);
    end else if (s >= (BYTE_W+1)'(2 * RESIDUE_MOD)) begin
      r = s - (BYTE_W+1)'(2 * RESIDUE_MOD);
    end else if (s >= (BYTE_W+1)'(RESIDUE_MOD)) begin
      r = s - (BYTE_W+1)'(RESIDUE_MOD);
    end else begin
      r = s;
    end
    return r[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ahba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ahba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/additive_hash_bucket_aggregator_top.sv -----
// Top level of the additive hash bucket aggregator: key hashing and bucket update.
// A key byte that is not the last one only moves the running residue (byte sum
// mod 101). A last key byte or a query passes the idle and update states: the
// bucket memory is read in the idle state and, for an add, written back in the
// update state, and no new item is taken while one is in the update state. The
// input side stays ready while a finished result waits in the output register; an
// item whose result finds the output register still full waits in the update state.
// The bucket memory is cleared at reset through per-entry valid bits, so no clearing
// pass is needed. Results carry the bucket's sum and count after the update (adds) or
// as stored (queries); a query of a bucket beyond the bucket count answers zero.
`default_nettype none
module additive_hash_bucket_aggregator_top
  import ahba_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: key_byte [7:0], speed_value [23:8], bucket_select [30:24], zero [31]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: bucket_index [6:0], total_speed [38:7], item_count [54:39], zero [55]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: answer_kind
  output logic                       m_axis_tuser
);

  logic [BYTE_W-1:0]  key_byte;
  logic [SPEED_W-1:0] speed_value;
  logic [SEL_W-1:0]   bucket_select;
  op_e                operation;

  assign key_byte      = s_axis_tdata[BYTE_W-1:0];
  assign speed_value   = s_axis_tdata[BYTE_W +: SPEED_W];
  assign bucket_select = s_axis_tdata[BYTE_W+SPEED_W +: SEL_W];
  assign operation     = op_e'(s_axis_tuser);

  state_e state_q, state_d;

  logic [RES_W-1:0]   residue_q, residue_d;
  logic [BUCKETS-1:0] valid_q, valid_d;
  logic               out_valid_q, out_valid_d;

  kind_e              kind_q;
  logic [SEL_W-1:0]   bidx_q;
  logic [BIDX_W-1:0]  addr_q;
  logic               in_range_q;
  logic [SPEED_W-1:0] speed_q;

  kind_e              out_kind_q;
  logic [SEL_W-1:0]   out_bidx_q;
  logic [SUM_W-1:0]   out_sum_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               accept;
  logic               needs_bucket;
  logic [RES_W-1:0]   res_new;
  logic [SEL_W-1:0]   hash_idx;
  logic [BIDX_W-1:0]  raddr;
  logic [SEL_W-1:0]   bidx_new;
  logic               in_range_new;

  bucket_entry_t      rd_entry;
  bucket_entry_t      cur_entry;
  bucket_entry_t      upd_entry;
  logic [SUM_W:0]     sum_wide;
  logic               out_free;
  logic               finish;
  logic               ram_we;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign res_new      = residue_add(residue_q, key_byte);
  assign hash_idx     = SEL_W'(res_new % BUCKETS);
  assign needs_bucket = (operation == OP_QUERY) || s_axis_tlast;
  assign bidx_new     = (operation == OP_QUERY) ? bucket_select : hash_idx;
  assign in_range_new = (operation == OP_QUERY) ? (bucket_select < SEL_W'(BUCKETS)) : 1'b1;
  // While a result waits, the held address keeps the read data valid.
  assign raddr        = (state_q == ST_UPDATE) ? addr_q : bidx_new[BIDX_W-1:0];

  ahba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (upd_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  // An entry never written since reset reads as zero.
  assign cur_entry = valid_q[addr_q] ? rd_entry : '0;

  always_comb begin
    sum_wide = {1'b0, cur_entry.sum} + {{(SUM_W+1-SPEED_W){1'b0}}, speed_q};
    upd_entry.sum   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    upd_entry.count = (cur_entry.count == {CNT_W{1'b1}}) ? cur_entry.count
                                                         : cur_entry.count + CNT_W'(1);
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign finish   = (state_q == ST_UPDATE) && out_free;
  assign ram_we   = finish && (kind_q == KIND_ACK);

  always_comb begin
    state_d     = state_q;
    residue_d   = residue_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (operation == OP_KEY_BYTE)) begin
          residue_d = s_axis_tlast ? '0 : res_new;
        end
        if (accept && needs_bucket) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (kind_q == KIND_ACK) begin
            valid_d[addr_q] = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      residue_q   <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      residue_q   <= residue_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && needs_bucket) begin
      kind_q     <= (operation == OP_QUERY) ? KIND_ANSWER : KIND_ACK;
      bidx_q     <= bidx_new;
      addr_q     <= raddr;
      in_range_q <= in_range_new;
      speed_q    <= speed_value;
    end
    if (finish) begin
      out_kind_q <= kind_q;
      out_bidx_q <= bidx_q;
      if (kind_q == KIND_ACK) begin
        out_sum_q <= upd_entry.sum;
        out_cnt_q <= upd_entry.count;
      end else if (in_range_q) begin
        out_sum_q <= cur_entry.sum;
        out_cnt_q <= cur_entry.count;
      end else begin
        out_sum_q <= '0;
        out_cnt_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_sum_q, out_bidx_q};

endmodule
`default_nettype wire

// ----- dv/additive_hash_bucket_aggregator_top_tb.sv -----
// Self-checking testbench for the additive hash bucket aggregator top level.
`timescale 1ns / 100ps
module additive_hash_bucket_aggregator_top_tb;
  import ahba_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPEAT_ADDS  = 40;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    kind_e             kind;
    logic [SEL_W-1:0]  bucket;
    logic [SUM_W-1:0]  total;
    logic [CNT_W-1:0]  count;
  } bucket_result_t;

  // Tracks the bucket stores and the running key residue, and holds the results still owed.
  class bucket_tally_board;
    int unsigned      key_residue = 0;
    logic [SUM_W-1:0] speed_sums  [BUCKETS];
    logic [CNT_W-1:0] item_counts [BUCKETS];
    bucket_result_t   owed[$];
    int unsigned      errors  = 0;
    int unsigned      acks    = 0;
    int unsigned      answers = 0;

    function void clear_stores();
      for (int b = 0; b < BUCKETS; b++) begin
        speed_sums[b]  = '0;
        item_counts[b] = '0;
      end
      key_residue = 0;
    endfunction

    function void note_item(op_e op, logic [BYTE_W-1:0] key_byte, logic key_last,
                            logic [SPEED_W-1:0] speed, logic [SEL_W-1:0] sel);
      bucket_result_t r;
      int unsigned    b;
      logic [SUM_W:0] wide_sum;
      if (op == OP_QUERY) begin
        r.kind   = KIND_ANSWER;
        r.bucket = sel;
        r.total  = (sel < BUCKETS) ? speed_sums[sel]  : '0;
        r.count  = (sel < BUCKETS) ? item_counts[sel] : '0;
        owed.push_back(r);
      end else begin
        key_residue = (key_residue + key_byte) % RESIDUE_MOD;
        if (key_last) begin
          b = key_residue % BUCKETS;
          wide_sum = {1'b0, speed_sums[b]} + speed;
          speed_sums[b] = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
          if (item_counts[b] != {CNT_W{1'b1}}) item_counts[b] = item_counts[b] + 1'b1;
          key_residue = 0;
          r.kind   = KIND_ACK;
          r.bucket = SEL_W'(b);
          r.total  = speed_sums[b];
          r.count  = item_counts[b];
          owed.push_back(r);
        end
      end
    endfunction

    function void check_result(logic kind_bit, logic [OUT_DATA_W-1:0] data);
      bucket_result_t exp_r;
      kind_e          kind;
      logic [SEL_W-1:0] bucket;
      logic [SUM_W-1:0] total;
      logic [CNT_W-1:0] count;
      kind   = kind_e'(kind_bit);
      bucket = data[6:0];
      total  = data[38:7];
      count  = data[54:39];
      if (owed.size() == 0) begin
        $error("result with no item owed: kind %0d bucket %0d", kind, bucket);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (kind == KIND_ACK) acks++;
      else answers++;
      if (kind != exp_r.kind) begin
        $error("answer_kind: expected %0d, got %0d", exp_r.kind, kind);
        errors++;
      end
      if (bucket != exp_r.bucket) begin
        $error("bucket_index: expected %0d, got %0d", exp_r.bucket, bucket);
        errors++;
      end
      if (total != exp_r.total) begin
        $error("total_speed: expected %0d, got %0d", exp_r.total, total);
        errors++;
      end
      if (count != exp_r.count) begin
        $error("item_count: expected %0d, got %0d", exp_r.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  bucket_tally_board tally;
  int unsigned accepted_items = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned cycle_count    = 0;

  additive_hash_bucket_aggregator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stalls, plus one long hold-off so the block backs up into its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= 300) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tally.check_result(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed", cycle_count, tally.owed.size());
      $display("additive_hash_bucket_aggregator_top verification failed");
      $finish;
    end
  end

  // Offers one item and waits for it to be taken; may then leave a short gap.
  task automatic send_item(input op_e op, input logic [BYTE_W-1:0] key_byte,
                           input logic key_last, input logic [SPEED_W-1:0] speed,
                           input logic [SEL_W-1:0] sel);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sel, speed, key_byte};
    s_axis_tuser  <= op;
    s_axis_tlast  <= key_last;
    do @(posedge clk_i); while (!s_axis_tready);
    tally.note_item(op, key_byte, key_last, speed, sel);
    accepted_items++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_query(input logic [SEL_W-1:0] sel);
    send_item(OP_QUERY, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
              SPEED_W'($urandom), sel);
  endtask

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return {SPEED_W{1'b1}};
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] pick_bucket();
    if ($urandom_range(9) < 7) return SEL_W'($urandom_range(BUCKETS - 1));
    return SEL_W'($urandom_range(100));
  endfunction

  // Whole keys of random length with random bytes, queries mixed in, some inside a key.
  task automatic run_random(input int unsigned item_total);
    int unsigned stop_at;
    int unsigned key_len;
    stop_at = accepted_items + item_total;
    while (accepted_items < stop_at) begin
      if ($urandom_range(3) == 0) begin
        send_query(pick_bucket());
      end else begin
        key_len = $urandom_range(1, 6);
        for (int i = 0; i < key_len; i++) begin
          if ($urandom_range(9) == 0) send_query(pick_bucket());
          send_item(OP_KEY_BYTE, BYTE_W'($urandom_range(255)), (i == key_len - 1),
                    pick_speed(), SEL_W'($urandom_range(100)));
        end
      end
    end
  endtask

  initial begin
    tally = new;
    tally.clear_stores();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 77;
    // Queries of cleared buckets, including indexes at and past the bucket count.
    send_query(0);
    send_query(SEL_W'(BUCKETS - 1));
    send_query(SEL_W'(BUCKETS));
    send_query(100);
    // Two largest bytes wrap the residue before the final byte adds the largest speed.
    send_item(OP_KEY_BYTE, 8'd255, 1'b0, 16'd0, 7'd0);
    send_item(OP_KEY_BYTE, 8'd255, 1'b0, 16'd0, 7'd0);
    send_item(OP_KEY_BYTE, 8'd0, 1'b1, 16'hFFFF, 7'd0);
    // The same query twice must not change the answer.
    send_query(5);
    send_query(5);
    // A query inside a key keeps the residue of the bytes taken so far.
    send_item(OP_KEY_BYTE, 8'd200, 1'b0, 16'd7, 7'd3);
    send_item(OP_QUERY, 8'd255, 1'b1, 16'hFFFF, 7'd2);
    send_item(OP_KEY_BYTE, 8'd100, 1'b1, 16'd1, 7'd0);
    send_query(2);
    // Single-byte key with zero speed still counts an item.
    send_item(OP_KEY_BYTE, 8'd0, 1'b1, 16'd0, 7'd0);
    send_query(0);
    send_query(7'd64);
    run_random(700);

    send_idle_pct = 77;
    recv_idle_pct = 24;
    run_random(700);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Pile back-to-back maximum-speed adds onto one bucket.
    for (int n = 0; n < REPEAT_ADDS; n++) send_item(OP_KEY_BYTE, 8'd7, 1'b1, 16'hFFFF, 7'd0);
    send_query(7);
    send_item(OP_KEY_BYTE, 8'd7, 1'b1, 16'd1, 7'd0);
    run_random(600);
    s_axis_tvalid <= 1'b0;

    while (tally.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run took %0d items in %0d cycles: %0d adds and %0d queries checked.",
             accepted_items, cycle_count, tally.acks, tally.answers);
    $display("Bucket 7 took a burst of largest-speed adds; idle mixes and a long hold-off ran.");
    if (tally.errors == 0) begin
      $display("additive_hash_bucket_aggregator_top verification clean");
    end else begin
      $display("additive_hash_bucket_aggregator_top verification failed");
    end
    $finish;
  end

endmodule
